[hdl/chunked_image_receiver_core_defines.svh]
// ----------------------------------------------------------------------------
// Chunked image receiver assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_IMAGE_RECEIVER_CORE_DEFINES_SVH
`define CHUNKED_IMAGE_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define CIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define CIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define CIR_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cir_pkg.sv]
// ----------------------------------------------------------------------------
// Chunked image receiver package
// Constants, register indexes, phase codes and the CRC-16 step.
// ----------------------------------------------------------------------------
package cir_pkg;

    localparam int CHUNK_BYTES = 512;
    localparam int ADDR_W      = $clog2(CHUNK_BYTES);
    localparam int LEN_W       = $clog2(CHUNK_BYTES + 1);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_BYTE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NAK_BYTE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAGING_BASE  = 3'd5;

    localparam logic [3:0]  RST_MAX_RETRIES   = 4'd5;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd2000;
    localparam logic [7:0]  RST_ACK_BYTE      = 8'hA5;
    localparam logic [7:0]  RST_NAK_BYTE      = 8'h5A;
    localparam logic [15:0] RST_CRC_INIT      = 16'hFFFF;

    // request kinds
    localparam logic [1:0] REQ_RX    = 2'd0;
    localparam logic [1:0] REQ_FLASH = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // flash commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_RETRIES = 3'd3;
    localparam logic [2:0] ST_FLASH   = 3'd4;

    // phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_ERASE  = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CRC    = 3'd4;
    localparam logic [2:0] PH_WRITE  = 3'd5;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  flash_cmd;
        logic [31:0] flash_offset;
        logic [31:0] flash_length;
        logic [2:0]  status;
    } res_t;

    // CRC-16/CCITT, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [31:0] left);
        logic [LEN_W-1:0] r;
        r = (left > 32'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES) : left[LEN_W-1:0];
        return r;
    endfunction

endpackage

[hdl/cir_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hdl/chunked_image_receiver_core.sv]
// ----------------------------------------------------------------------------
// Chunked image receiver core
// Stop-and-wait chunk receiver with CRC-16 check and chunk buffer.
// ----------------------------------------------------------------------------
// Result path: buffer RAM read stage, then output register. Each byte's CRC
//   step and buffer write are done as the byte is accepted.
// Throughput: one item per cycle while the result output is not stalled.
// Reset: synchronous, active low; control state and config registers return to
//   defaults, buffer contents are left as they are (no clearing pass).
module chunked_image_receiver_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] rx_data, [8] flash_ok, [17:9] read_index, rest zero
    input  logic [cir_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] req_type
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] tx_valid, [8:1] tx_byte, [40:9] flash_offset, [72:41] flash_length,
    // [80:73] read_data, [83:81] status, rest zero
    output logic [cir_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] flash_cmd
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [cir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cir_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cir_pkg::*;

    // configuration
    logic [3:0]  max_retries_reg;
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  ack_byte_reg;
    logic [7:0]  nak_byte_reg;
    logic [15:0] crc_init_reg;
    logic [31:0] staging_base_reg;

    // transfer state
    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       prefix_cnt_reg, prefix_cnt_next;
    logic [31:0]      image_len_reg, image_len_next;
    logic [31:0]      bytes_done_reg, bytes_done_next;
    logic [31:0]      remain_reg, remain_next;
    logic [LEN_W-1:0] seg_len_reg, seg_len_next;
    logic [LEN_W-1:0] chunk_pos_reg, chunk_pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic             crc_pos_reg, crc_pos_next;
    logic [3:0]       attempt_reg, attempt_next;
    logic [15:0]      idle_ticks_reg, idle_ticks_next;

    // pipeline
    logic  p1_valid_reg;
    res_t  p1_res_reg;
    logic  p1_rd_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    logic [7:0] out_rdata_reg;

    logic        accept, p1_move;
    res_t        res;
    logic        rd_hit;
    logic        buf_we;
    logic [7:0]  ram_q;
    logic [1:0]  req_type;
    logic [7:0]  rx_data;
    logic        flash_ok;
    logic [8:0]  read_index;
    logic [3:0]  limit;
    logic [3:0]  attempt_inc;
    logic [15:0] ticks_inc;
    logic [31:0] image_new;
    logic [31:0] remain_sub;
    logic [LEN_W-1:0] pos_inc;

    assign req_type   = s_tuser;
    assign rx_data    = s_tdata[7:0];
    assign flash_ok   = s_tdata[8];
    assign read_index = s_tdata[17:9];

    assign p1_move  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_move;
    assign accept   = s_tvalid && s_tready;

    assign limit       = (max_retries_reg == 4'd0) ? 4'd1 : max_retries_reg;
    assign attempt_inc = attempt_reg + 4'd1;
    assign ticks_inc   = (idle_ticks_reg == 16'hFFFF) ? idle_ticks_reg : idle_ticks_reg + 16'd1;
    assign remain_sub  = remain_reg - 32'(seg_len_reg);
    assign pos_inc     = chunk_pos_reg + LEN_W'(1);

    always_comb begin
        image_new = image_len_reg;
        unique case (prefix_cnt_reg)
            2'd1: image_new[15:8]  = rx_data;
            2'd2: image_new[23:16] = rx_data;
            2'd3: image_new[31:24] = rx_data;
            default: image_new[7:0] = rx_data;
        endcase
    end

    always_comb begin
        phase_next      = phase_reg;
        prefix_cnt_next = prefix_cnt_reg;
        image_len_next  = image_len_reg;
        bytes_done_next = bytes_done_reg;
        remain_next     = remain_reg;
        seg_len_next    = seg_len_reg;
        chunk_pos_next  = chunk_pos_reg;
        crc_next        = crc_reg;
        crc_lo_next     = crc_lo_reg;
        crc_pos_next    = crc_pos_reg;
        attempt_next    = attempt_reg;
        idle_ticks_next = idle_ticks_reg;
        res             = '0;
        rd_hit          = 1'b0;
        buf_we          = 1'b0;

        if (accept) begin
            unique case (req_type)
                REQ_RX: begin
                    idle_ticks_next = '0;
                    unique case (phase_reg)
                        PH_IDLE: begin
                            image_len_next  = {24'd0, rx_data};
                            prefix_cnt_next = 2'd1;
                            phase_next      = PH_PREFIX;
                        end
                        PH_PREFIX: begin
                            image_len_next  = image_new;
                            prefix_cnt_next = prefix_cnt_reg + 2'd1;
                            if (prefix_cnt_reg == 2'd3) begin
                                bytes_done_next  = '0;
                                remain_next      = image_new;
                                res.flash_cmd    = CMD_ERASE;
                                res.flash_offset = staging_base_reg;
                                res.flash_length = image_new;
                                phase_next       = PH_ERASE;
                            end
                        end
                        PH_DATA: begin
                            buf_we         = 32'(chunk_pos_reg) < 32'(CHUNK_BYTES);
                            crc_next       = crc_step(crc_reg, rx_data);
                            chunk_pos_next = pos_inc;
                            if (pos_inc >= seg_len_reg) begin
                                phase_next   = PH_CRC;
                                crc_pos_next = 1'b0;
                            end
                        end
                        PH_CRC: begin
                            if (!crc_pos_reg) begin
                                crc_lo_next  = rx_data;
                                crc_pos_next = 1'b1;
                            end else begin
                                crc_pos_next = 1'b0;
                                if ({rx_data, crc_lo_reg} == crc_reg) begin
                                    res.flash_cmd    = CMD_WRITE;
                                    res.flash_offset = staging_base_reg + bytes_done_reg;
                                    res.flash_length = 32'(seg_len_reg);
                                    phase_next       = PH_WRITE;
                                end else begin
                                    res.tx_valid = 1'b1;
                                    res.tx_byte  = nak_byte_reg;
                                    attempt_next = attempt_inc;
                                    if (attempt_inc >= limit) begin
                                        res.status = ST_RETRIES;
                                        phase_next = PH_IDLE;
                                    end else begin
                                        chunk_pos_next = '0;
                                        crc_next       = crc_init_reg;
                                        phase_next     = PH_DATA;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                REQ_FLASH: begin
                    if (phase_reg == PH_ERASE || phase_reg == PH_WRITE) begin
                        if (!flash_ok) begin
                            res.status = ST_FLASH;
                            phase_next = PH_IDLE;
                        end else begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = ack_byte_reg;
                            if (phase_reg == PH_WRITE) begin
                                bytes_done_next = bytes_done_reg + 32'(seg_len_reg);
                                remain_next     = remain_sub;
                            end
                            if ((phase_reg == PH_WRITE) ? (remain_sub == '0)
                                                        : (remain_reg == '0)) begin
                                res.status = ST_OK;
                                phase_next = PH_IDLE;
                            end else begin
                                seg_len_next    = clamp_len((phase_reg == PH_WRITE) ?
                                                            remain_sub : remain_reg);
                                chunk_pos_next  = '0;
                                crc_pos_next    = 1'b0;
                                crc_next        = crc_init_reg;
                                idle_ticks_next = '0;
                                attempt_next    = '0;
                                phase_next      = PH_DATA;
                            end
                        end
                    end
                end
                REQ_TICK: begin
                    if (phase_reg == PH_PREFIX || phase_reg == PH_DATA
                        || phase_reg == PH_CRC) begin
                        idle_ticks_next = ticks_inc;
                        if (ticks_inc >= timeout_ticks_reg) begin
                            res.status = ST_TIMEOUT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                REQ_READ: begin
                    rd_hit = 32'(read_index) < 32'(CHUNK_BYTES);
                end
                default: ;
            endcase
        end

        if (phase_next == PH_IDLE) begin
            prefix_cnt_next = '0;
            idle_ticks_next = '0;
        end
    end

    cir_ram #(
        .WIDTH (8),
        .DEPTH (CHUNK_BYTES)
    ) u_chunk_ram (
        .clk   (aclk),
        .we    (buf_we),
        .waddr (chunk_pos_reg[ADDR_W-1:0]),
        .wdata (rx_data),
        .re    (rd_hit),
        .raddr (ADDR_W'(read_index)),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg   <= RST_MAX_RETRIES;
            timeout_ticks_reg <= RST_TIMEOUT_TICKS;
            ack_byte_reg      <= RST_ACK_BYTE;
            nak_byte_reg      <= RST_NAK_BYTE;
            crc_init_reg      <= RST_CRC_INIT;
            staging_base_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_RETRIES:   max_retries_reg   <= cfg_data[3:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                REG_ACK_BYTE:      ack_byte_reg      <= cfg_data[7:0];
                REG_NAK_BYTE:      nak_byte_reg      <= cfg_data[7:0];
                REG_CRC_INIT:      crc_init_reg      <= cfg_data[15:0];
                REG_STAGING_BASE:  staging_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            prefix_cnt_reg <= '0;
            image_len_reg  <= '0;
            bytes_done_reg <= '0;
            remain_reg     <= '0;
            seg_len_reg    <= '0;
            chunk_pos_reg  <= '0;
            crc_reg        <= RST_CRC_INIT;
            crc_lo_reg     <= '0;
            crc_pos_reg    <= 1'b0;
            attempt_reg    <= '0;
            idle_ticks_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            prefix_cnt_reg <= prefix_cnt_next;
            image_len_reg  <= image_len_next;
            bytes_done_reg <= bytes_done_next;
            remain_reg     <= remain_next;
            seg_len_reg    <= seg_len_next;
            chunk_pos_reg  <= chunk_pos_next;
            crc_reg        <= crc_next;
            crc_lo_reg     <= crc_lo_next;
            crc_pos_reg    <= crc_pos_next;
            attempt_reg    <= attempt_next;
            idle_ticks_reg <= idle_ticks_next;
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload; RAM output holds until the next buffer read is accepted
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= res;
            p1_rd_reg  <= rd_hit;
        end
        if (p1_move) begin
            out_res_reg   <= p1_res_reg;
            out_rdata_reg <= p1_rd_reg ? ram_q : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.flash_cmd;
    assign m_tdata  = {4'd0, out_res_reg.status, out_rdata_reg, out_res_reg.flash_length,
                       out_res_reg.flash_offset, out_res_reg.tx_byte, out_res_reg.tx_valid};
endmodule

[hdl/cir_checker.sv]
// ----------------------------------------------------------------------------
// Chunked image receiver port checker
// Checks result items and handshake seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "chunked_image_receiver_core_defines.svh"

module cir_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cir_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser
);
    import cir_pkg::*;

    `CIR_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")
    `CIR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item dropped or changed")
    `CIR_ASSERT_NOW(a_no_cmd_zero, m_tvalid && m_tuser == CMD_NONE, m_tdata[72:9] == '0, "offset or length without command")
    `CIR_ASSERT_NOW(a_tx_byte, m_tvalid && !m_tdata[0], m_tdata[8:1] == '0, "tx byte without tx valid")
endmodule

bind chunked_image_receiver_core cir_checker u_cir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/chunked_image_receiver_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked image receiver checker
// Watches the item, result and register ports, predicts each result from its
// own copy of the receiver state and compares all fields in order.
// ----------------------------------------------------------------------------
module chunked_image_receiver_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cir_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [cir_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]                     m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [cir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cir_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import cir_pkg::*;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  cmd;
        logic [31:0] offset;
        logic [31:0] length;
        logic [7:0]  rdata;
        logic [2:0]  status;
    } reply_t;

    // register copies
    logic [3:0]  retries_cfg;
    logic [15:0] timeout_cfg;
    logic [7:0]  ack_cfg, nak_cfg;
    logic [15:0] crc_init_cfg;
    logic [31:0] base_cfg;

    // receiver state
    logic [2:0]  phase;
    logic [1:0]  prefix_cnt;
    logic [31:0] image_len, done_bytes;
    logic [9:0]  seg_len, chunk_pos;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic        crc_second;
    logic [3:0]  attempts;
    logic [15:0] ticks;
    logic [7:0]  chunk_buf [CHUNK_BYTES];

    reply_t reply_q [$];
    int     mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    task automatic open_chunk(input bit fresh);
        logic [31:0] left;
        left       = image_len - done_bytes;
        seg_len    = (left > CHUNK_BYTES) ? 10'(CHUNK_BYTES) : left[9:0];
        chunk_pos  = '0;
        crc_second = 1'b0;
        crc_acc    = crc_init_cfg;
        ticks      = '0;
        if (fresh) attempts = '0;
        phase = PH_DATA;
    endtask

    task automatic step_receiver(input logic [1:0] req, input logic [7:0] rx, input logic ok,
                                 input logic [8:0] idx, output reply_t r);
        logic [3:0] limit;
        r     = '0;
        limit = (retries_cfg == 0) ? 4'd1 : retries_cfg;
        case (req)
            REQ_RX: begin
                ticks = '0;
                case (phase)
                    PH_IDLE: begin
                        image_len  = {24'd0, rx};
                        prefix_cnt = 2'd1;
                        phase      = PH_PREFIX;
                    end
                    PH_PREFIX: begin
                        image_len  = image_len | ({24'd0, rx} << (8 * prefix_cnt));
                        prefix_cnt = prefix_cnt + 2'd1;
                        if (prefix_cnt == 0) begin
                            done_bytes = '0;
                            r.cmd      = CMD_ERASE;
                            r.offset   = base_cfg;
                            r.length   = image_len;
                            phase      = PH_ERASE;
                        end
                    end
                    PH_DATA: begin
                        chunk_buf[chunk_pos[8:0]] = rx;
                        crc_acc   = crc16_next(crc_acc, rx);
                        chunk_pos = chunk_pos + 10'd1;
                        if (chunk_pos >= seg_len) begin
                            phase      = PH_CRC;
                            crc_second = 1'b0;
                        end
                    end
                    PH_CRC: begin
                        if (!crc_second) begin
                            crc_lo     = rx;
                            crc_second = 1'b1;
                        end else begin
                            crc_second = 1'b0;
                            if ({rx, crc_lo} == crc_acc) begin
                                r.cmd    = CMD_WRITE;
                                r.offset = base_cfg + done_bytes;
                                r.length = {22'd0, seg_len};
                                phase    = PH_WRITE;
                            end else begin
                                r.tx_valid = 1'b1;
                                r.tx_byte  = nak_cfg;
                                attempts   = attempts + 4'd1;
                                if (attempts >= limit) begin
                                    r.status = ST_RETRIES;
                                    phase    = PH_IDLE;
                                end else begin
                                    open_chunk(1'b0);
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            REQ_FLASH: begin
                if (phase == PH_ERASE || phase == PH_WRITE) begin
                    if (!ok) begin
                        r.status = ST_FLASH;
                        phase    = PH_IDLE;
                    end else begin
                        if (phase == PH_WRITE) done_bytes = done_bytes + 32'(seg_len);
                        r.tx_valid = 1'b1;
                        r.tx_byte  = ack_cfg;
                        if (done_bytes >= image_len) begin
                            r.status = ST_OK;
                            phase    = PH_IDLE;
                        end else begin
                            open_chunk(1'b1);
                        end
                    end
                end
            end
            REQ_TICK: begin
                if (phase == PH_PREFIX || phase == PH_DATA || phase == PH_CRC) begin
                    if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
                    if (ticks >= timeout_cfg) begin
                        r.status = ST_TIMEOUT;
                        phase    = PH_IDLE;
                    end
                end
            end
            default: r.rdata = chunk_buf[idx];
        endcase
        if (phase == PH_IDLE) begin
            prefix_cnt = '0;
            ticks      = '0;
        end
    endtask

    task automatic compare_reply(input reply_t got);
        reply_t want;
        if (reply_q.size() == 0) begin
            if (mismatches < 10) $display("checker: unexpected result %h", got);
            mismatches++;
            return;
        end
        want = reply_q.pop_front();
        if (got !== want) begin
            if (mismatches < 10)
                $display({"checker: mismatch tx %0b/%h cmd %0d off %h len %h rd %h st %0d,",
                          " expected tx %0b/%h cmd %0d off %h len %h rd %h st %0d"},
                         got.tx_valid, got.tx_byte, got.cmd, got.offset, got.length, got.rdata,
                         got.status, want.tx_valid, want.tx_byte, want.cmd, want.offset,
                         want.length, want.rdata, want.status);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t r;
        if (!aresetn) begin
            retries_cfg  = RST_MAX_RETRIES;
            timeout_cfg  = RST_TIMEOUT_TICKS;
            ack_cfg      = RST_ACK_BYTE;
            nak_cfg      = RST_NAK_BYTE;
            crc_init_cfg = RST_CRC_INIT;
            base_cfg     = '0;
            phase        = PH_IDLE;
            prefix_cnt   = '0;
            image_len    = '0;
            done_bytes   = '0;
            seg_len      = '0;
            chunk_pos    = '0;
            crc_acc      = RST_CRC_INIT;
            crc_lo       = '0;
            crc_second   = 1'b0;
            attempts     = '0;
            ticks        = '0;
            reply_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                compare_reply({m_tdata[0], m_tdata[8:1], m_tuser, m_tdata[40:9],
                               m_tdata[72:41], m_tdata[80:73], m_tdata[83:81]});
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_RETRIES:   retries_cfg  = cfg_data[3:0];
                    REG_TIMEOUT_TICKS: timeout_cfg  = cfg_data[15:0];
                    REG_ACK_BYTE:      ack_cfg      = cfg_data[7:0];
                    REG_NAK_BYTE:      nak_cfg      = cfg_data[7:0];
                    REG_CRC_INIT:      crc_init_cfg = cfg_data[15:0];
                    REG_STAGING_BASE:  base_cfg     = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                step_receiver(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[17:9], r);
                reply_q.push_back(r);
            end
        end
        pending <= reply_q.size();
    end

endmodule

[test/chunked_image_receiver_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked image receiver testbench
// Drives whole downloads with random payloads, corrupted CRCs, flash
// failures, timeouts and stray events over several register settings, with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module chunked_image_receiver_core_tb;
    import cir_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic [1:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [1:0]              m_tuser;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int fail_count, pending;
    int stall_cnt = 0;
    int items = 0;
    int hwm = 0;             // leading buffer entries known to be written
    bit no_idle = 0;
    bit hold_req = 0;

    // register mirrors used to shape the stimulus
    int          tmo_now = RST_TIMEOUT_TICKS;
    int          limit_now = RST_MAX_RETRIES;
    logic [15:0] crc_seed = RST_CRC_INIT;

    chunked_image_receiver_core DUT (.*);

    chunked_image_receiver_checker u_chk (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            stall_cnt++;
            if (stall_cnt == WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end else begin
            stall_cnt = 0;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
                m_tready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [1:0] req, input logic [7:0] rx, input logic ok,
                        input logic [8:0] idx);
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, idx, ok, rx};
        do @(posedge aclk); while (!s_tready);
        if (req == REQ_RX || req == REQ_FLASH) items++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send(REQ_RX, b, 1'($urandom), 9'($urandom));
    endtask

    task automatic flash_done(input logic ok);
        send(REQ_FLASH, 8'($urandom), ok, 9'($urandom));
    endtask

    task automatic tick();
        send(REQ_TICK, 8'($urandom), 1'($urandom), 9'($urandom));
    endtask

    task automatic buf_read();
        if (hwm > 0) send(REQ_READ, 8'($urandom), 1'($urandom), 9'($urandom_range(0, hwm - 1)));
    endtask

    // stray events while waiting for a byte; may end the transfer by timeout
    task automatic before_byte(input bit may_fail, output bit ended);
        int k;
        ended = 0;
        case ($urandom_range(0, 19))
            0: buf_read();
            1: flash_done(1'($urandom));   // ignored outside a flash wait
            default: ;
        endcase
        if (may_fail && tmo_now <= 20 && $urandom_range(0, 99) < 3) begin
            repeat (tmo_now) tick();
            ended = 1;
        end else if (tmo_now > 1 && $urandom_range(0, 9) == 0) begin
            k = $urandom_range(1, (tmo_now - 1 < 4) ? tmo_now - 1 : 4);
            repeat (k) tick();
        end
    endtask

    // stray events during an erase or write wait; bytes and ticks are ignored
    task automatic flash_wait_noise();
        case ($urandom_range(0, 9))
            0: put_byte(8'($urandom));
            1: tick();
            2: buf_read();
            default: ;
        endcase
    endtask

    task automatic download(input int len, input bit may_fail);
        bit          ended, bad;
        int          done_len, clen, tries;
        logic [15:0] crc;
        logic [7:0]  b;
        for (int i = 0; i < 4; i++) begin
            if (i > 0) begin
                before_byte(may_fail, ended);
                if (ended) return;
            end
            put_byte(8'(len >> (8 * i)));
        end
        flash_wait_noise();
        if (may_fail && $urandom_range(0, 99) < 4) begin
            flash_done(1'b0);
            return;
        end
        flash_done(1'b1);
        done_len = 0;
        while (done_len < len) begin
            clen  = (len - done_len > CHUNK_BYTES) ? CHUNK_BYTES : len - done_len;
            tries = 0;
            forever begin
                crc = crc_seed;
                for (int p = 0; p < clen; p++) begin
                    before_byte(may_fail, ended);
                    if (ended) return;
                    b   = 8'($urandom);
                    crc = u_chk.crc16_next(crc, b);
                    put_byte(b);
                    if (p + 1 > hwm) hwm = p + 1;
                end
                bad = may_fail && $urandom_range(0, 99) < 15;
                if (bad) crc = crc ^ 16'($urandom_range(1, 65535));
                before_byte(may_fail, ended);
                if (ended) return;
                put_byte(crc[7:0]);
                before_byte(may_fail, ended);
                if (ended) return;
                put_byte(crc[15:8]);
                if (!bad) break;
                tries++;
                if (tries >= limit_now) return;
            end
            flash_wait_noise();
            if (may_fail && $urandom_range(0, 99) < 3) begin
                flash_done(1'b0);
                return;
            end
            flash_done(1'b1);
            done_len += clen;
        end
    endtask

    // a start that never completes
    task automatic broken_start();
        if (tmo_now <= 20) begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
            repeat (tmo_now) tick();
        end else begin
            repeat (4) put_byte(8'($urandom));
            flash_done(1'b0);
        end
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [3:0]  retries_v [6] = '{4'd0, 4'd1, 4'd15, 4'd5, 4'd3, 4'd2};
        int          tmo_v     [6] = '{65535, 1, 3, 2000, 10, 6};
        logic [7:0]  ack_v     [6] = '{8'h00, 8'hFF, 8'h3C, 8'hA5, 8'h81, 8'h7E};
        logic [7:0]  nak_v     [6] = '{8'hFF, 8'h00, 8'hC3, 8'h5A, 8'h18, 8'hE7};
        logic [15:0] crc_v     [6] = '{16'h0000, 16'hFFFF, 16'h1D0F, 16'h8000, 16'h0001, 16'h5555};
        logic [31:0] base_v    [6] = '{32'h0, 32'hFFFF_FFFF, 32'h0800_4000, 32'h0,
                                       32'hFFFF_FF00, 32'h1234_5678};
        int phase_start;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ignored events in idle, empty image, a short image,
        // largest length with failed erase, buffer reads
        tick();
        flash_done(1'b1);
        download(0, 0);
        download(2, 0);
        buf_read();
        buf_read();
        repeat (4) put_byte(8'hFF);
        flash_done(1'b0);
        settle();

        for (int p = 0; p < 6; p++) begin
            crc_seed  = (p == 5) ? 16'($urandom) : crc_v[p];
            tmo_now   = tmo_v[p];
            limit_now = (retries_v[p] == 0) ? 1 : retries_v[p];
            set_reg(REG_MAX_RETRIES, {28'd0, retries_v[p]});
            set_reg(REG_TIMEOUT_TICKS, tmo_now);
            set_reg(REG_ACK_BYTE, {24'd0, (p == 5) ? 8'($urandom) : ack_v[p]});
            set_reg(REG_NAK_BYTE, {24'd0, nak_v[p]});
            set_reg(REG_CRC_INIT, {16'd0, crc_seed});
            set_reg(REG_STAGING_BASE, (p == 5) ? 32'($urandom) : base_v[p]);
            cfg_wr_en <= 1'b0;
            no_idle = (p == 3);
            if (p == 0) download(530, 0);    // spans two chunks, fills the buffer
            if (p == 2) hold_req = 1;
            phase_start = items;
            while (items - phase_start < 30) begin
                if ($urandom_range(0, 99) < 85) download($urandom_range(0, 24), 1);
                else broken_start();
                if ($urandom_range(0, 3) == 0) buf_read();
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[chunked_image_receiver_core.f]
+incdir+hdl
hdl/cir_pkg.sv
hdl/cir_ram.sv
hdl/chunked_image_receiver_core.sv
hdl/cir_checker.sv
test/chunked_image_receiver_checker.sv
test/chunked_image_receiver_core_tb.sv
